[hdl/aat_pkg.sv]
// Shared types and constants for the axis-aligned box transform block.
// Used by the front, queue, back, top level and checker files.
// Depends on nothing else.
package aat_pkg;

  // Fixed-point format of every coordinate and matrix coefficient.
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;

  // Full-precision product and four-term sum widths.
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 2;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Matrix shape: three stored rows of three coefficients and a translation.
  localparam int AXES     = 3;
  localparam int ROW_TERMS = AXES + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // Item kind codes as they arrive on the input channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  // Matrix row codes carried by a load word.
  localparam logic [1:0] ROW_X    = 2'd0;
  localparam logic [1:0] ROW_Y    = 2'd1;
  localparam logic [1:0] ROW_Z    = 2'd2;
  localparam logic [1:0] ROW_NONE = 2'd3;

  // Operation held in a queue entry.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BOX  = 1'b1
  } op_t;

  // One queue entry. A load keeps coef x, y, z and translation in data[0..3];
  // a box keeps min x, y, z in data[0..2] and max x, y, z in data[3..5].
  typedef struct packed {
    op_t          op;
    logic [1:0]   row;
    coord_t [5:0] data;
  } q_entry_t;

  // Queue status seen by both neighbors.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Reset diagonal value (1.0) and saturation limits.
  localparam coord_t ONE_VAL = coord_t'(64'(1) << FRAC_BITS);
  localparam coord_t SAT_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t SAT_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

endpackage

[hdl/aat_front.sv]
// Front part: input register that accepts words and classifies them.
// Pushes loads and boxes into the queue and drops loads to row three.
// Depends on aat_pkg.
module aat_front
  import aat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_kind,
  input  logic [1:0] in_row_index,
  input  coord_t    in_coef_x,
  input  coord_t    in_coef_y,
  input  coord_t    in_coef_z,
  input  coord_t    in_coef_shift,
  input  coord_t    in_box_min_x,
  input  coord_t    in_box_min_y,
  input  coord_t    in_box_min_z,
  input  coord_t    in_box_max_x,
  input  coord_t    in_box_max_y,
  input  coord_t    in_box_max_z,
  input  q_status_t q_status,
  output logic      push,
  output q_entry_t  push_entry
);

  logic     front_valid_r, front_valid_nxt;
  logic     keep_r, keep_nxt;
  q_entry_t entry_r, entry_nxt;
  logic     accept;
  logic     drain;

  // The stage stalls only when it holds a word the full queue cannot take.
  assign in_stall = front_valid_r && keep_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid_r && keep_r && !q_status.full;
  assign drain    = front_valid_r && !in_stall;
  assign push_entry = entry_r;

  // Classify the incoming word.
  always_comb begin
    entry_nxt     = '0;
    keep_nxt      = 1'b1;
    entry_nxt.row = in_row_index;
    unique case (in_kind)
      KIND_BOX: begin
        entry_nxt.op      = OP_BOX;
        entry_nxt.data[0] = in_box_min_x;
        entry_nxt.data[1] = in_box_min_y;
        entry_nxt.data[2] = in_box_min_z;
        entry_nxt.data[3] = in_box_max_x;
        entry_nxt.data[4] = in_box_max_y;
        entry_nxt.data[5] = in_box_max_z;
      end
      default: begin
        entry_nxt.op      = OP_LOAD;
        entry_nxt.data[0] = in_coef_x;
        entry_nxt.data[1] = in_coef_y;
        entry_nxt.data[2] = in_coef_z;
        entry_nxt.data[3] = in_coef_shift;
        keep_nxt          = (in_row_index != ROW_NONE);
      end
    endcase
  end

  // Occupancy of the input register.
  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (drain) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  // Payload register, loaded on every accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
      keep_r  <= keep_nxt;
    end
  end

endmodule

[hdl/aat_queue.sv]
// Short queue that decouples the front part from the back part.
// Holds loads and boxes in arrival order so matrix updates stay ordered.
// Depends on aat_pkg.
module aat_queue
  import aat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_status
);

  q_entry_t             q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = q_mem_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hdl/aat_back.sv]
// Back part: matrix rows and the four-stage box transform pipeline.
// Stage one multiplies, two picks min/max per term, three sums, four saturates.
// Depends on aat_pkg.
module aat_back
  import aat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output coord_t    out_min_x,
  output coord_t    out_min_y,
  output coord_t    out_min_z,
  output coord_t    out_max_x,
  output coord_t    out_max_y,
  output coord_t    out_max_z
);

  coord_t coef_r [AXES][ROW_TERMS];

  logic   s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  prod_t  s1_lo_r [AXES][AXES];
  prod_t  s1_hi_r [AXES][AXES];
  coord_t s1_tr_r [AXES];
  prod_t  s2_mn_r [AXES][AXES];
  prod_t  s2_mx_r [AXES][AXES];
  coord_t s2_tr_r [AXES];
  sum_t   s3_min_r [AXES];
  sum_t   s3_max_r [AXES];
  coord_t out_min_r [AXES];
  coord_t out_max_r [AXES];

  sum_t   shr_min [AXES];
  sum_t   shr_max [AXES];
  coord_t sat_min [AXES];
  coord_t sat_max [AXES];

  logic   adv;
  logic   is_box;

  // The whole pipeline moves when the output register is free.
  assign adv    = !out_valid_r || !out_stall;
  assign pop    = adv && !q_status.empty;
  assign is_box = (head.op == OP_BOX);

  // Matrix rows: identity after reset, one row written per load word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < AXES; r++) begin
        for (int k = 0; k < ROW_TERMS; k++) begin
          coef_r[r][k] <= (r == k) ? ONE_VAL : '0;
        end
      end
    end else if (pop && !is_box) begin
      for (int r = 0; r < AXES; r++) begin
        if (head.row == 2'(r)) begin
          for (int k = 0; k < ROW_TERMS; k++) begin
            coef_r[r][k] <= head.data[k];
          end
        end
      end
    end
  end

  // Valid bits of the pipeline; only boxes travel down it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop && is_box;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Stage one: each coefficient times the min and the max of its axis.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        for (int j = 0; j < AXES; j++) begin
          s1_lo_r[a][j] <= PROD_W'(coef_r[a][j]) * PROD_W'(head.data[j]);
          s1_hi_r[a][j] <= PROD_W'(coef_r[a][j]) * PROD_W'(head.data[AXES + j]);
        end
        s1_tr_r[a] <= coef_r[a][AXES];
      end
    end
  end

  // Stage two: the sum over corners is separable, so the extreme corner
  // takes the smaller or larger product of each term independently.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        for (int j = 0; j < AXES; j++) begin
          if (s1_lo_r[a][j] < s1_hi_r[a][j]) begin
            s2_mn_r[a][j] <= s1_lo_r[a][j];
            s2_mx_r[a][j] <= s1_hi_r[a][j];
          end else begin
            s2_mn_r[a][j] <= s1_hi_r[a][j];
            s2_mx_r[a][j] <= s1_lo_r[a][j];
          end
        end
        s2_tr_r[a] <= s1_tr_r[a];
      end
    end
  end

  // Stage three: full-precision sums with the scaled translation.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        s3_min_r[a] <= (SUM_W'(s2_tr_r[a]) <<< FRAC_BITS) + SUM_W'(s2_mn_r[a][0])
                     + SUM_W'(s2_mn_r[a][1]) + SUM_W'(s2_mn_r[a][2]);
        s3_max_r[a] <= (SUM_W'(s2_tr_r[a]) <<< FRAC_BITS) + SUM_W'(s2_mx_r[a][0])
                     + SUM_W'(s2_mx_r[a][1]) + SUM_W'(s2_mx_r[a][2]);
      end
    end
  end

  // Stage four: floor shift and saturation to the coordinate range.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      shr_min[a] = s3_min_r[a] >>> FRAC_BITS;
      shr_max[a] = s3_max_r[a] >>> FRAC_BITS;
      if (shr_min[a] > SUM_W'(SAT_MAX)) begin
        sat_min[a] = SAT_MAX;
      end else if (shr_min[a] < SUM_W'(SAT_MIN)) begin
        sat_min[a] = SAT_MIN;
      end else begin
        sat_min[a] = shr_min[a][COORD_W-1:0];
      end
      if (shr_max[a] > SUM_W'(SAT_MAX)) begin
        sat_max[a] = SAT_MAX;
      end else if (shr_max[a] < SUM_W'(SAT_MIN)) begin
        sat_max[a] = SAT_MIN;
      end else begin
        sat_max[a] = shr_max[a][COORD_W-1:0];
      end
    end
  end

  // Output register holds the word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        out_min_r[a] <= sat_min[a];
        out_max_r[a] <= sat_max[a];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_min_x = out_min_r[0];
  assign out_min_y = out_min_r[1];
  assign out_min_z = out_min_r[2];
  assign out_max_x = out_max_r[0];
  assign out_max_y = out_max_r[1];
  assign out_max_z = out_max_r[2];

endmodule

[hdl/aabb_affine_transform.sv]
// Top level of the axis-aligned box transform by an affine matrix.
// Connects aat_front, aat_queue and aat_back; depends on aat_pkg.
//
//   Channel  Handshake          Moves
//   in_      in_valid/in_stall  one load word (matrix row) or one box word
//   out_     out_valid/out_stall one transformed box word per box word
//
// One word is accepted per cycle when nothing stalls; a box word passes through
// the input register, the queue, the multiply, min/max pick and sum stages,
// then the saturating output register.
// The 18 parallel 32x32 multipliers of the multiply stage set the rate.
// Reset restores the identity matrix and empties every stage and the queue.
// An output stall freezes the back pipeline; the four-entry queue keeps the
// input open until it fills.
module aabb_affine_transform
  import aat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [1:0] in_row_index,
  input  coord_t     in_coef_x,
  input  coord_t     in_coef_y,
  input  coord_t     in_coef_z,
  input  coord_t     in_coef_shift,
  input  coord_t     in_box_min_x,
  input  coord_t     in_box_min_y,
  input  coord_t     in_box_min_z,
  input  coord_t     in_box_max_x,
  input  coord_t     in_box_max_y,
  input  coord_t     in_box_max_z,
  output logic       out_valid,
  input  logic       out_stall,
  output coord_t     out_min_x,
  output coord_t     out_min_y,
  output coord_t     out_min_z,
  output coord_t     out_max_x,
  output coord_t     out_max_y,
  output coord_t     out_max_z
);

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  // Front: accept and classify.
  aat_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_coef_x    (in_coef_x),
    .in_coef_y    (in_coef_y),
    .in_coef_z    (in_coef_z),
    .in_coef_shift(in_coef_shift),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Queue between front and back.
  aat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // Back: matrix and transform pipeline.
  aat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_min_x (out_min_x),
    .out_min_y (out_min_y),
    .out_min_z (out_min_z),
    .out_max_x (out_max_x),
    .out_max_y (out_max_y),
    .out_max_z (out_max_z)
  );

endmodule

[hdl/aat_checker.sv]
// Port-level checks for the box transform top level, attached by bind.
// Depends on aat_pkg and the aabb_affine_transform port list.
module aat_checker
  import aat_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_kind,
  input logic [1:0] in_row_index,
  input coord_t     in_coef_x,
  input coord_t     in_coef_y,
  input coord_t     in_coef_z,
  input coord_t     in_coef_shift,
  input coord_t     in_box_min_x,
  input coord_t     in_box_min_y,
  input coord_t     in_box_min_z,
  input coord_t     in_box_max_x,
  input coord_t     in_box_max_y,
  input coord_t     in_box_max_z,
  input logic       out_valid,
  input logic       out_stall,
  input coord_t     out_min_x,
  input coord_t     out_min_y,
  input coord_t     out_min_z,
  input coord_t     out_max_x,
  input coord_t     out_max_y,
  input coord_t     out_max_z
);

  // A stalled input word stays valid and keeps its payload.
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_row_index)
      && $stable(in_coef_x) && $stable(in_coef_y) && $stable(in_coef_z)
      && $stable(in_coef_shift) && $stable(in_box_min_x) && $stable(in_box_min_y)
      && $stable(in_box_min_z) && $stable(in_box_max_x) && $stable(in_box_max_y)
      && $stable(in_box_max_z))
    else $error("input word changed while stalled");

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_min_x) && $stable(out_min_y)
      && $stable(out_min_z) && $stable(out_max_x) && $stable(out_max_y)
      && $stable(out_max_z))
    else $error("result word changed while stalled");

  // The transformed box is never inverted on any axis.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
      && (out_min_z <= out_max_z))
    else $error("transformed box has min above max");

  // Reset leaves no result pending and the input open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the pipeline");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);
